FILE: sv/clts_pkg.sv
// ============================================================================
// clts_pkg
// Shared types, token codes and character classifiers for the token scanner.
// ============================================================================
package clts_pkg;

    // Token kinds
    localparam logic [6:0] K_DOT         = 7'd7;
    localparam logic [6:0] K_SLASH       = 7'd19;
    localparam logic [6:0] K_SLASH_EQUAL = 7'd20;
    localparam logic [6:0] K_IDENT       = 7'd41;
    localparam logic [6:0] K_CHARACTER   = 7'd42;
    localparam logic [6:0] K_STRING      = 7'd43;
    localparam logic [6:0] K_NUMBER      = 7'd44;
    localparam logic [6:0] K_KEYWORD0    = 7'd45;
    localparam logic [6:0] K_ERROR       = 7'd72;
    localparam logic [6:0] K_EOF         = 7'd73;

    // Error codes
    localparam logic [2:0] E_NONE        = 3'd0;
    localparam logic [2:0] E_UNEXPECTED  = 3'd1;
    localparam logic [2:0] E_STR_UNTERM  = 3'd2;
    localparam logic [2:0] E_STR_MULTI   = 3'd3;
    localparam logic [2:0] E_CHR_UNTERM  = 3'd4;
    localparam logic [2:0] E_CHR_MULTI   = 3'd5;

    localparam int KW_COUNT    = 27;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] CH_CR = 8'h0D;

    typedef enum logic [9:0] {
        M_IDLE    = 10'b00_0000_0001,
        M_SLASH   = 10'b00_0000_0010,
        M_COMMENT = 10'b00_0000_0100,
        M_IDENT   = 10'b00_0000_1000,
        M_INT     = 10'b00_0001_0000,
        M_DOT     = 10'b00_0010_0000,
        M_FRAC    = 10'b00_0100_0000,
        M_STRING  = 10'b00_1000_0000,
        M_CHAR    = 10'b01_0000_0000,
        M_OP      = 10'b10_0000_0000
    } scan_mode_t;

    typedef struct packed {
        logic [7:0] char_in;
        logic       end_of_text;
    } in_beat_t;

    typedef struct packed {
        logic [6:0]  token_kind;
        logic [2:0]  error_code;
        logic [23:0] start_offset;
        logic [23:0] token_length;
        logic [23:0] line_number;
        logic        last_of_run;
    } out_beat_t;

    // Up to three result beats caused by one input beat
    typedef struct packed {
        logic [1:0]      count;
        out_beat_t [2:0] tok;
    } group_t;

    // Keywords, left aligned, first character in the top byte
    localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
        {"break", 24'd0}, {"case", 32'd0}, {"char", 32'd0}, {"const", 24'd0},
        "continue", {"default", 8'd0}, {"do", 48'd0}, {"double", 16'd0},
        {"else", 32'd0}, {"enum", 32'd0}, {"float", 24'd0}, {"for", 40'd0},
        {"goto", 32'd0}, {"if", 48'd0}, {"int", 40'd0}, {"long", 32'd0},
        {"return", 16'd0}, {"short", 24'd0}, {"signed", 16'd0},
        {"sizeof", 16'd0}, {"struct", 16'd0}, {"switch", 16'd0},
        {"typedef", 8'd0}, {"union", 24'd0}, "unsigned", {"void", 32'd0},
        {"while", 24'd0}
    };
    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd5, 4'd4, 4'd4, 4'd5, 4'd8, 4'd7, 4'd2, 4'd6, 4'd4, 4'd4, 4'd5,
        4'd3, 4'd4, 4'd2, 4'd3, 4'd4, 4'd6, 4'd5, 4'd6, 4'd6, 4'd6, 4'd6,
        4'd7, 4'd5, 4'd8, 4'd4, 4'd5
    };

    function automatic logic is_alpha(logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
    endfunction

    function automatic logic is_digit(logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    // {hit, kind}
    function automatic logic [7:0] single_kind(logic [7:0] b);
        logic [7:0] r;
        case (b)
            "(":     r = {1'b1, 7'd0};
            ")":     r = {1'b1, 7'd1};
            "[":     r = {1'b1, 7'd2};
            "]":     r = {1'b1, 7'd3};
            "{":     r = {1'b1, 7'd4};
            "}":     r = {1'b1, 7'd5};
            ",":     r = {1'b1, 7'd6};
            ".":     r = {1'b1, 7'd7};
            ";":     r = {1'b1, 7'd8};
            "~":     r = {1'b1, 7'd9};
            default: r = 8'd0;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] op_alone(logic [7:0] b);
        logic [7:0] r;
        case (b)
            "+":     r = {1'b1, 7'd10};
            "-":     r = {1'b1, 7'd13};
            "*":     r = {1'b1, 7'd17};
            "%":     r = {1'b1, 7'd21};
            "&":     r = {1'b1, 7'd23};
            "|":     r = {1'b1, 7'd26};
            "^":     r = {1'b1, 7'd29};
            "=":     r = {1'b1, 7'd31};
            "!":     r = {1'b1, 7'd33};
            "<":     r = {1'b1, 7'd35};
            ">":     r = {1'b1, 7'd38};
            default: r = 8'd0;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] op_pair(logic [7:0] f, logic [7:0] s);
        logic [7:0] r;
        r = 8'd0;
        case (f)
            "+":
            begin
                if (s == "+") r = {1'b1, 7'd11};
                if (s == "=") r = {1'b1, 7'd12};
            end
            "-":
            begin
                if (s == "-") r = {1'b1, 7'd14};
                if (s == "=") r = {1'b1, 7'd15};
                if (s == ">") r = {1'b1, 7'd16};
            end
            "*": if (s == "=") r = {1'b1, 7'd18};
            "%": if (s == "=") r = {1'b1, 7'd22};
            "^": if (s == "=") r = {1'b1, 7'd30};
            "=": if (s == "=") r = {1'b1, 7'd32};
            "!": if (s == "=") r = {1'b1, 7'd34};
            "&":
            begin
                if (s == "=") r = {1'b1, 7'd24};
                if (s == "&") r = {1'b1, 7'd25};
            end
            "|":
            begin
                if (s == "=") r = {1'b1, 7'd27};
                if (s == "|") r = {1'b1, 7'd28};
            end
            "<":
            begin
                if (s == "=") r = {1'b1, 7'd36};
                if (s == "<") r = {1'b1, 7'd37};
            end
            ">":
            begin
                if (s == "=") r = {1'b1, 7'd39};
                if (s == ">") r = {1'b1, 7'd40};
            end
            default: r = 8'd0;
        endcase
        return r;
    endfunction

    // Identifier or keyword kind from the first eight prefix bytes and length
    function automatic logic [6:0] kw_kind(logic [63:0] p, logic [3:0] n);
        logic [6:0] r;
        logic       hit;
        r = K_IDENT;
        for (int k = 0; k < KW_COUNT; k++)
        begin
            hit = (KW_LEN[k] == n);
            for (int i = 0; i < 8; i++)
            begin
                if (4'(i) < n && p[63-8*i -: 8] != KW_TEXT[k][63-8*i -: 8])
                    hit = 1'b0;
            end
            if (hit)
                r = K_KEYWORD0 + 7'(k);
        end
        return r;
    endfunction

endpackage

FILE: sv/c_lexer_token_scanner_core.sv
// ============================================================================
// c_lexer_token_scanner_core
// C lexical scanner: source bytes in, tokens with offset, length, line out.
// ============================================================================
// The first token of a beat is written into the group queue before it is valid at the output.
// Throughput: one input beat per cycle while the queue is not full; the tokens
// of a beat leave one by one, each as its own output beat.
// A four-group queue separates the scanner from the output stage.
// Reset clears scan state, counters (line to 1) and the queue; no sweep.
module c_lexer_token_scanner_core
    import clts_pkg::*;
#(
    parameter int POSITION_BITS = 24,
    parameter int KEYWORD_MAX   = 8
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_beat_t  in_beat,
    output logic      out_valid,
    input  logic      out_ready,
    output out_beat_t out_beat
);

    logic   q_push, q_full, q_pop, q_empty;
    group_t q_group, q_head;

    clts_front #(
        .POSITION_BITS (POSITION_BITS),
        .KEYWORD_MAX   (KEYWORD_MAX)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_beat  (in_beat),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_group  (q_group)
    );

    clts_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_group (q_group),
        .full       (q_full),
        .pop        (q_pop),
        .head       (q_head),
        .empty      (q_empty)
    );

    clts_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (q_head),
        .empty     (q_empty),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_beat  (out_beat)
    );

    // An end marker always produces a group
    a_eot_push: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_beat.end_of_text) |-> q_push)
        else $error("end marker produced no tokens");

    // EOF closes the run of its beat
    a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_beat.token_kind == K_EOF) |-> out_beat.last_of_run)
        else $error("EOF not last of run");

    // Error code only on error tokens
    a_err_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((out_beat.error_code != E_NONE) == (out_beat.token_kind == K_ERROR)))
        else $error("error code and kind disagree");

    // Queued groups are never empty
    a_group_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> (q_group.count != 2'd0))
        else $error("empty group queued");

endmodule

FILE: sv/clts_front.sv
// ============================================================================
// clts_front
// Byte classifier and scan state: turns one beat into a group of tokens.
// ============================================================================
module clts_front
    import clts_pkg::*;
#(
    parameter int POSITION_BITS = 24,
    parameter int KEYWORD_MAX   = 8
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_beat_t in_beat,
    input  logic     q_full,
    output logic     q_push,
    output group_t   q_group
);

    localparam int PB = POSITION_BITS;
    localparam int PW = (PB > 24) ? PB : 24;
    localparam int CW = $clog2(KEYWORD_MAX + 2);

    typedef struct packed {
        logic [6:0]    kind;
        logic [2:0]    err;
        logic [PB-1:0] first;
        logic [PB-1:0] last;
    } raw_tok_t;

    scan_mode_t    mode_reg, mode_next;
    logic [7:0]    pend_reg, pend_next;
    logic [PB-1:0] pos_reg, pos_next;
    logic [PB-1:0] begin_reg, begin_next;
    logic [PB-1:0] line_reg, line_next;
    logic [PB-1:0] dot_reg, dot_next;
    logic [CW-1:0] pcount_reg, pcount_next;
    logic [7:0]    prefix_reg [KEYWORD_MAX];
    logic [7:0]    prefix_next [KEYWORD_MAX];

    logic          accept;
    logic [7:0]    b;
    logic [PB-1:0] end_pos;
    logic [63:0]   p64;
    logic [3:0]    plen;
    logic [6:0]    id_kind;
    logic [7:0]    pair_k, alone_k, pend_alone, single_k;
    logic          a0_v, a1_v, b_v, idle_go;
    raw_tok_t      a0, a1, bt;
    logic [1:0]    n;

    function automatic logic [PB-1:0] sat(logic [PB-1:0] x);
        return (&x) ? x : x + 1'b1;
    endfunction

    function automatic logic [23:0] clip(logic [PB-1:0] x);
        logic [PW-1:0] w;
        w = PW'(x);
        return (w > PW'(24'hFF_FFFF)) ? 24'hFF_FFFF : w[23:0];
    endfunction

    function automatic out_beat_t cook(raw_tok_t t, logic [PB-1:0] ln, logic lst);
        out_beat_t o;
        o.token_kind   = t.kind;
        o.error_code   = t.err;
        o.start_offset = clip(t.first);
        o.token_length = clip(t.last - t.first);
        o.line_number  = clip(ln);
        o.last_of_run  = lst;
        return o;
    endfunction

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign b        = in_beat.char_in;
    assign end_pos  = sat(pos_reg);

    // Keyword compare on the stored prefix
    always_comb
    begin
        for (int i = 0; i < 8; i++)
            p64[63-8*i -: 8] = prefix_reg[i];
        plen    = (pcount_reg > CW'(8)) ? 4'd15 : 4'(pcount_reg);
        id_kind = kw_kind(p64, plen);
    end

    assign pair_k     = op_pair(pend_reg, b);
    assign pend_alone = op_alone(pend_reg);
    assign alone_k    = op_alone(b);
    assign single_k   = single_kind(b);

    // Scan one beat
    always_comb
    begin
        mode_next   = mode_reg;
        pend_next   = pend_reg;
        pos_next    = pos_reg;
        begin_next  = begin_reg;
        line_next   = line_reg;
        dot_next    = dot_reg;
        pcount_next = pcount_reg;
        prefix_next = prefix_reg;
        a0_v = 1'b0;
        a1_v = 1'b0;
        b_v  = 1'b0;
        a0   = '{kind: K_ERROR, err: E_NONE, first: begin_reg, last: pos_reg};
        a1   = '{kind: K_DOT, err: E_NONE, first: dot_reg, last: sat(dot_reg)};
        bt   = '{kind: K_ERROR, err: E_UNEXPECTED, first: pos_reg, last: end_pos};
        idle_go = 1'b0;

        if (in_beat.end_of_text)
        begin
            // Flush pending token, then EOF
            case (mode_reg)
                M_SLASH:
                begin
                    a0_v = 1'b1; a0.kind = K_SLASH;
                end
                M_IDENT:
                begin
                    a0_v = 1'b1; a0.kind = id_kind;
                end
                M_INT, M_FRAC:
                begin
                    a0_v = 1'b1; a0.kind = K_NUMBER;
                end
                M_DOT:
                begin
                    a0_v = 1'b1; a0.kind = K_NUMBER; a0.last = dot_reg; a1_v = 1'b1;
                end
                M_STRING:
                begin
                    a0_v = 1'b1; a0.err = E_STR_UNTERM;
                end
                M_CHAR:
                begin
                    a0_v = 1'b1; a0.err = E_CHR_UNTERM;
                end
                M_OP:
                begin
                    a0_v = 1'b1;
                    if (pend_alone[7])
                        a0.kind = pend_alone[6:0];
                    else
                        a0.err = E_UNEXPECTED;
                end
                default: ;
            endcase
            b_v      = 1'b1;
            bt.kind  = K_EOF;
            bt.err   = E_NONE;
            bt.last  = pos_reg;
            mode_next   = M_IDLE;
            pend_next   = 8'd0;
            pos_next    = '0;
            begin_next  = '0;
            line_next   = PB'(1);
            dot_next    = '0;
            pcount_next = '0;
        end
        else
        begin
            pos_next = end_pos;
            case (mode_reg)
                M_IDLE: idle_go = 1'b1;
                M_SLASH:
                begin
                    if (b == "/")
                        mode_next = M_COMMENT;
                    else if (b == "=")
                    begin
                        a0_v = 1'b1; a0.kind = K_SLASH_EQUAL; a0.last = end_pos;
                        mode_next = M_IDLE;
                    end
                    else
                    begin
                        a0_v = 1'b1; a0.kind = K_SLASH; idle_go = 1'b1;
                    end
                end
                M_COMMENT:
                begin
                    if (b == "\n")
                    begin
                        line_next = sat(line_reg);
                        mode_next = M_IDLE;
                    end
                end
                M_IDENT:
                begin
                    if (is_alpha(b) || is_digit(b))
                    begin
                        for (int i = 0; i < KEYWORD_MAX; i++)
                            if (pcount_reg == CW'(i))
                                prefix_next[i] = b;
                        if (pcount_reg <= CW'(KEYWORD_MAX))
                            pcount_next = pcount_reg + 1'b1;
                    end
                    else
                    begin
                        a0_v = 1'b1; a0.kind = id_kind; idle_go = 1'b1;
                    end
                end
                M_INT:
                begin
                    if (b == ".")
                    begin
                        dot_next  = pos_reg;
                        mode_next = M_DOT;
                    end
                    else if (!is_digit(b))
                    begin
                        a0_v = 1'b1; a0.kind = K_NUMBER; idle_go = 1'b1;
                    end
                end
                M_DOT:
                begin
                    if (is_digit(b))
                        mode_next = M_FRAC;
                    else
                    begin
                        a0_v = 1'b1; a0.kind = K_NUMBER; a0.last = dot_reg;
                        a1_v = 1'b1; idle_go = 1'b1;
                    end
                end
                M_FRAC:
                begin
                    if (!is_digit(b))
                    begin
                        a0_v = 1'b1; a0.kind = K_NUMBER; idle_go = 1'b1;
                    end
                end
                M_STRING:
                begin
                    if (b == "\"")
                    begin
                        a0_v = 1'b1; a0.kind = K_STRING; a0.last = end_pos;
                        mode_next = M_IDLE;
                    end
                    else if (b == "\n")
                    begin
                        a0_v = 1'b1; a0.err = E_STR_MULTI; idle_go = 1'b1;
                    end
                end
                M_CHAR:
                begin
                    if (b == "'")
                    begin
                        a0_v = 1'b1; a0.kind = K_CHARACTER; a0.last = end_pos;
                        mode_next = M_IDLE;
                    end
                    else if (b == "\n")
                    begin
                        a0_v = 1'b1; a0.err = E_CHR_MULTI; idle_go = 1'b1;
                    end
                end
                M_OP:
                begin
                    a0_v = 1'b1;
                    if (pair_k[7])
                    begin
                        a0.kind = pair_k[6:0]; a0.last = end_pos;
                        mode_next = M_IDLE;
                    end
                    else
                    begin
                        if (pend_alone[7])
                            a0.kind = pend_alone[6:0];
                        else
                            a0.err = E_UNEXPECTED;
                        idle_go = 1'b1;
                    end
                end
                default: idle_go = 1'b1;
            endcase

            // Start of a new token, or skip blanks
            if (idle_go)
            begin
                mode_next = M_IDLE;
                if (b == " " || b == CH_CR || b == "\t")
                    mode_next = M_IDLE;
                else if (b == "\n")
                    line_next = sat(line_reg);
                else
                begin
                    begin_next = pos_reg;
                    if (b == "/")
                        mode_next = M_SLASH;
                    else if (b == "\"")
                        mode_next = M_STRING;
                    else if (b == "'")
                        mode_next = M_CHAR;
                    else if (is_alpha(b))
                    begin
                        prefix_next[0] = b;
                        pcount_next    = CW'(1);
                        mode_next      = M_IDENT;
                    end
                    else if (is_digit(b))
                        mode_next = M_INT;
                    else if (single_k[7])
                    begin
                        b_v = 1'b1; bt.kind = single_k[6:0]; bt.err = E_NONE;
                    end
                    else if (alone_k[7])
                    begin
                        pend_next = b;
                        mode_next = M_OP;
                    end
                    else
                        b_v = 1'b1;
                end
            end
        end
    end

    // Pack the tokens into consecutive slots
    always_comb
    begin
        n = 2'(a0_v) + 2'(a1_v) + 2'(b_v);
        q_group.count  = n;
        q_group.tok[0] = cook(a0_v ? a0 : bt, line_reg, n == 2'd1);
        q_group.tok[1] = cook(a1_v ? a1 : bt, line_reg, n == 2'd2);
        q_group.tok[2] = cook(bt, line_reg, 1'b1);
        q_push = accept && (n != 2'd0);
    end

    // Hold scan state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= M_IDLE;
            pend_reg   <= 8'd0;
            pos_reg    <= '0;
            begin_reg  <= '0;
            line_reg   <= PB'(1);
            dot_reg    <= '0;
            pcount_reg <= '0;
        end
        else if (accept)
        begin
            mode_reg   <= mode_next;
            pend_reg   <= pend_next;
            pos_reg    <= pos_next;
            begin_reg  <= begin_next;
            line_reg   <= line_next;
            dot_reg    <= dot_next;
            pcount_reg <= pcount_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            prefix_reg <= prefix_next;
    end

endmodule

FILE: sv/clts_queue.sv
// ============================================================================
// clts_queue
// Short FIFO of token groups between the scanner and the output stage.
// ============================================================================
module clts_queue
    import clts_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  group_t push_group,
    output logic   full,
    input  logic   pop,
    output group_t head,
    output logic   empty
);

    group_t               slot_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_reg, rd_reg;
    logic [QPTR_BITS:0]   level_reg, level_next;

    assign full  = (level_reg == (QPTR_BITS+1)'(QUEUE_DEPTH));
    assign empty = (level_reg == '0);
    assign head  = slot_reg[rd_reg];

    always_comb
    begin
        level_next = level_reg;
        if (push && !pop)
            level_next = level_reg + 1'b1;
        else if (pop && !push)
            level_next = level_reg - 1'b1;
    end

    // Advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            level_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + 1'b1;
            if (pop)
                rd_reg <= rd_reg + 1'b1;
            level_reg <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_reg] <= push_group;
    end

endmodule

FILE: sv/clts_back.sv
// ============================================================================
// clts_back
// Output stage: hands out the tokens of the head group one beat at a time.
// ============================================================================
module clts_back
    import clts_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  group_t    head,
    input  logic      empty,
    output logic      pop,
    output logic      out_valid,
    input  logic      out_ready,
    output out_beat_t out_beat
);

    logic [1:0] idx_reg, idx_next;
    logic       take;

    assign out_valid = !empty;
    assign out_beat  = head.tok[idx_reg];
    assign take      = out_valid && out_ready;
    assign pop       = take && (idx_reg == head.count - 2'd1);

    always_comb
    begin
        idx_next = idx_reg;
        if (pop)
            idx_next = 2'd0;
        else if (take)
            idx_next = idx_reg + 2'd1;
    end

    // Step through the group
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= 2'd0;
        else
            idx_reg <= idx_next;
    end

endmodule

FILE: verif/c_lexer_token_scanner_core_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// c_lexer_token_scanner_core_tb
// Feeds C-like source text (directed fragments, then random well-formed
// fragments mixed with noise bytes and end markers) through the scanner.
// Every accepted byte is run through a local token predictor. Each token beat
// is checked field by field against the oldest predicted token.
// ============================================================================
module c_lexer_token_scanner_core_tb;

    typedef enum int {
        LX_IDLE, LX_SLASH, LX_COMMENT, LX_IDENT, LX_INT, LX_DOT, LX_FRAC,
        LX_STRING, LX_CHAR, LX_OP
    } lex_state_t;

    localparam logic [23:0] POS_TOP    = 24'hFFFFFF;
    localparam int          KW_SPAN    = 8;
    localparam int          CYCLE_CAP  = 200000;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    clts_pkg::in_beat_t    in_beat;
    logic                  out_valid;
    logic                  out_ready;
    clts_pkg::out_beat_t   out_beat;

    c_lexer_token_scanner_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_beat   (in_beat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_beat  (out_beat)
    );

    string kw_words [27] = '{
        "break", "case", "char", "const", "continue", "default", "do", "double",
        "else", "enum", "float", "for", "goto", "if", "int", "long", "return",
        "short", "signed", "sizeof", "struct", "switch", "typedef", "union",
        "unsigned", "void", "while"
    };

    clts_pkg::in_beat_t  source_q [$];
    clts_pkg::out_beat_t token_q [$];
    clts_pkg::out_beat_t step_tokens [$];

    // Predictor state
    lex_state_t  lx_state;
    logic [7:0]  lx_op;
    logic [23:0] lx_pos;
    logic [23:0] lx_begin;
    logic [23:0] lx_line;
    logic [23:0] lx_dot;
    logic [7:0]  lx_pfx [KW_SPAN];
    int          lx_pcnt;

    int  fail_count;
    int  bytes_taken;
    int  tokens_seen;
    int  errors_seen;
    int  keywords_seen;
    int  cycle_count;
    bit  idle_on;

    function automatic logic [23:0] inc24(logic [23:0] x);
        return (x == POS_TOP) ? x : x + 24'd1;
    endfunction

    function automatic int punct_kind(logic [7:0] b);
        case (b)
            "(": return 0;
            ")": return 1;
            "[": return 2;
            "]": return 3;
            "{": return 4;
            "}": return 5;
            ",": return 6;
            ".": return 7;
            ";": return 8;
            "~": return 9;
            default: return -1;
        endcase
    endfunction

    function automatic int lone_op(logic [7:0] b);
        case (b)
            "+": return 10;
            "-": return 13;
            "*": return 17;
            "%": return 21;
            "&": return 23;
            "|": return 26;
            "^": return 29;
            "=": return 31;
            "!": return 33;
            "<": return 35;
            ">": return 38;
            default: return -1;
        endcase
    endfunction

    function automatic int pair_op(logic [7:0] f, logic [7:0] s);
        case ({f, s})
            {"+", "+"}: return 11;
            {"+", "="}: return 12;
            {"-", "-"}: return 14;
            {"-", "="}: return 15;
            {"-", ">"}: return 16;
            {"*", "="}: return 18;
            {"%", "="}: return 22;
            {"&", "="}: return 24;
            {"&", "&"}: return 25;
            {"|", "="}: return 27;
            {"|", "|"}: return 28;
            {"^", "="}: return 30;
            {"=", "="}: return 32;
            {"!", "="}: return 34;
            {"<", "="}: return 36;
            {"<", "<"}: return 37;
            {">", "="}: return 39;
            {">", ">"}: return 40;
            default: return -1;
        endcase
    endfunction

    function automatic bit is_letter(logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
    endfunction

    function automatic bit is_num(logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    task automatic push_token(logic [6:0] kind, logic [2:0] err,
                              logic [23:0] b, logic [23:0] e);
        clts_pkg::out_beat_t t;
        t.token_kind   = kind;
        t.error_code   = err;
        t.start_offset = b;
        t.token_length = (e >= b) ? e - b : 24'd0;
        t.line_number  = lx_line;
        t.last_of_run  = 1'b0;
        step_tokens.push_back(t);
    endtask

    function automatic logic [6:0] word_kind();
        bit hit;
        if (lx_pcnt > KW_SPAN)
            return clts_pkg::K_IDENT;
        for (int k = 0; k < 27; k++)
        begin
            if (kw_words[k].len() != lx_pcnt)
                continue;
            hit = 1'b1;
            for (int i = 0; i < lx_pcnt; i++)
                if (lx_pfx[i] != kw_words[k][i])
                    hit = 1'b0;
            if (hit)
                return clts_pkg::K_KEYWORD0 + 7'(k);
        end
        return clts_pkg::K_IDENT;
    endfunction

    task automatic add_letter(logic [7:0] b);
        if (lx_pcnt < KW_SPAN)
            lx_pfx[lx_pcnt] = b;
        if (lx_pcnt <= KW_SPAN)
            lx_pcnt++;
    endtask

    task automatic clear_state();
        lx_state = LX_IDLE;
        lx_op    = 8'd0;
        lx_pos   = 24'd0;
        lx_begin = 24'd0;
        lx_line  = 24'd1;
        lx_dot   = 24'd0;
        lx_pcnt  = 0;
        foreach (lx_pfx[i])
            lx_pfx[i] = 8'd0;
    endtask

    // Start a fresh token from byte b, or skip blanks and newlines
    task automatic begin_token(logic [7:0] b);
        int k;
        lx_state = LX_IDLE;
        if (b == " " || b == "\t" || b == clts_pkg::CH_CR)
            return;
        if (b == "\n")
        begin
            lx_line = inc24(lx_line);
            return;
        end
        lx_begin = lx_pos;
        if (b == "/")
            lx_state = LX_SLASH;
        else if (b == "\"")
            lx_state = LX_STRING;
        else if (b == "'")
            lx_state = LX_CHAR;
        else if (is_letter(b))
        begin
            lx_pcnt = 0;
            add_letter(b);
            lx_state = LX_IDENT;
        end
        else if (is_num(b))
            lx_state = LX_INT;
        else if ((k = punct_kind(b)) >= 0)
            push_token(7'(k), clts_pkg::E_NONE, lx_pos, inc24(lx_pos));
        else if (lone_op(b) >= 0)
        begin
            lx_op    = b;
            lx_state = LX_OP;
        end
        else
            push_token(clts_pkg::K_ERROR, clts_pkg::E_UNEXPECTED, lx_pos, inc24(lx_pos));
    endtask

    task automatic close_dotted();
        push_token(clts_pkg::K_NUMBER, clts_pkg::E_NONE, lx_begin, lx_dot);
        push_token(clts_pkg::K_DOT, clts_pkg::E_NONE, lx_dot, inc24(lx_dot));
    endtask

    // Advance the pending token by one byte; rescan the byte if it ends one
    task automatic scan_char(logic [7:0] b);
        logic [23:0] e;
        int          k;
        bit          rescan;
        e      = inc24(lx_pos);
        rescan = 1'b1;
        case (lx_state)
            LX_IDLE: ;
            LX_SLASH:
                if (b == "/")
                begin
                    lx_state = LX_COMMENT;
                    rescan   = 1'b0;
                end
                else if (b == "=")
                begin
                    push_token(clts_pkg::K_SLASH_EQUAL, clts_pkg::E_NONE, lx_begin, e);
                    lx_state = LX_IDLE;
                    rescan   = 1'b0;
                end
                else
                    push_token(clts_pkg::K_SLASH, clts_pkg::E_NONE, lx_begin, lx_pos);
            LX_COMMENT:
            begin
                rescan = 1'b0;
                if (b == "\n")
                begin
                    lx_line  = inc24(lx_line);
                    lx_state = LX_IDLE;
                end
            end
            LX_IDENT:
                if (is_letter(b) || is_num(b))
                begin
                    add_letter(b);
                    rescan = 1'b0;
                end
                else
                    push_token(word_kind(), clts_pkg::E_NONE, lx_begin, lx_pos);
            LX_INT:
                if (is_num(b))
                    rescan = 1'b0;
                else if (b == ".")
                begin
                    lx_dot   = lx_pos;
                    lx_state = LX_DOT;
                    rescan   = 1'b0;
                end
                else
                    push_token(clts_pkg::K_NUMBER, clts_pkg::E_NONE, lx_begin, lx_pos);
            LX_DOT:
                if (is_num(b))
                begin
                    lx_state = LX_FRAC;
                    rescan   = 1'b0;
                end
                else
                    close_dotted();
            LX_FRAC:
                if (is_num(b))
                    rescan = 1'b0;
                else
                    push_token(clts_pkg::K_NUMBER, clts_pkg::E_NONE, lx_begin, lx_pos);
            LX_STRING:
                if (b == "\"")
                begin
                    push_token(clts_pkg::K_STRING, clts_pkg::E_NONE, lx_begin, e);
                    lx_state = LX_IDLE;
                    rescan   = 1'b0;
                end
                else if (b != "\n")
                    rescan = 1'b0;
                else
                    push_token(clts_pkg::K_ERROR, clts_pkg::E_STR_MULTI, lx_begin, lx_pos);
            LX_CHAR:
                if (b == "'")
                begin
                    push_token(clts_pkg::K_CHARACTER, clts_pkg::E_NONE, lx_begin, e);
                    lx_state = LX_IDLE;
                    rescan   = 1'b0;
                end
                else if (b != "\n")
                    rescan = 1'b0;
                else
                    push_token(clts_pkg::K_ERROR, clts_pkg::E_CHR_MULTI, lx_begin, lx_pos);
            LX_OP:
            begin
                k = pair_op(lx_op, b);
                if (k >= 0)
                begin
                    push_token(7'(k), clts_pkg::E_NONE, lx_begin, e);
                    lx_state = LX_IDLE;
                    rescan   = 1'b0;
                end
                else
                    push_token(7'(lone_op(lx_op)), clts_pkg::E_NONE, lx_begin, lx_pos);
            end
        endcase
        if (rescan)
            begin_token(b);
    endtask

    // Flush the pending token at the end marker
    task automatic flush_token();
        case (lx_state)
            LX_SLASH:  push_token(clts_pkg::K_SLASH, clts_pkg::E_NONE, lx_begin, lx_pos);
            LX_IDENT:  push_token(word_kind(), clts_pkg::E_NONE, lx_begin, lx_pos);
            LX_INT, LX_FRAC:
                       push_token(clts_pkg::K_NUMBER, clts_pkg::E_NONE, lx_begin, lx_pos);
            LX_DOT:    close_dotted();
            LX_STRING: push_token(clts_pkg::K_ERROR, clts_pkg::E_STR_UNTERM, lx_begin, lx_pos);
            LX_CHAR:   push_token(clts_pkg::K_ERROR, clts_pkg::E_CHR_UNTERM, lx_begin, lx_pos);
            LX_OP:     push_token(7'(lone_op(lx_op)), clts_pkg::E_NONE, lx_begin, lx_pos);
            default: ;
        endcase
    endtask

    // Predict the tokens caused by one accepted source beat
    task automatic predict_tokens(clts_pkg::in_beat_t bt);
        clts_pkg::out_beat_t t;
        step_tokens.delete();
        if (bt.end_of_text)
        begin
            flush_token();
            push_token(clts_pkg::K_EOF, clts_pkg::E_NONE, lx_pos, lx_pos);
            clear_state();
        end
        else
        begin
            if (lx_state == LX_IDLE)
                begin_token(bt.char_in);
            else
                scan_char(bt.char_in);
            lx_pos = inc24(lx_pos);
        end
        if (step_tokens.size() > 0)
            step_tokens[step_tokens.size() - 1].last_of_run = 1'b1;
        foreach (step_tokens[i])
        begin
            t = step_tokens[i];
            token_q.push_back(t);
        end
    endtask

    task automatic report(string field, int got, int want);
        $display("[%0t] mismatch on %s: got %0d, want %0d", $time, field, got, want);
        fail_count++;
    endtask

    // Stimulus builders
    task automatic add_text(string s);
        clts_pkg::in_beat_t bt;
        for (int i = 0; i < s.len(); i++)
        begin
            bt.char_in     = s[i];
            bt.end_of_text = 1'b0;
            source_q.push_back(bt);
        end
    endtask

    task automatic add_byte(logic [7:0] b);
        clts_pkg::in_beat_t bt;
        bt.char_in     = b;
        bt.end_of_text = 1'b0;
        source_q.push_back(bt);
    endtask

    task automatic add_end();
        clts_pkg::in_beat_t bt;
        bt.char_in     = 8'($urandom);
        bt.end_of_text = 1'b1;
        source_q.push_back(bt);
    endtask

    // One random fragment, mostly well formed
    task automatic add_fragment();
        string alnum;
        string opch;
        alnum = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
        opch  = "+-*%&|^=!<>/.;,(){}[]~";
        case ($urandom_range(11))
            0, 1: add_text(kw_words[$urandom_range(26)]);
            2:
            begin
                add_byte(alnum[$urandom_range(52)]);
                repeat ($urandom_range(9))
                    add_byte(alnum[$urandom_range(62)]);
            end
            3:
            begin
                repeat ($urandom_range(1, 3))
                    add_byte(8'("0") + 8'($urandom_range(9)));
                if ($urandom_range(1))
                    add_byte(".");
                repeat ($urandom_range(2))
                    add_byte(8'("0") + 8'($urandom_range(9)));
            end
            4:
            begin
                add_byte("\"");
                repeat ($urandom_range(3))
                    add_byte(alnum[$urandom_range(62)]);
                if ($urandom_range(5) != 0)
                    add_byte("\"");
            end
            5:
            begin
                add_byte("'");
                add_byte(alnum[$urandom_range(62)]);
                if ($urandom_range(5) != 0)
                    add_byte("'");
            end
            6, 7:
                repeat ($urandom_range(1, 2))
                    add_byte(opch[$urandom_range(opch.len() - 1)]);
            8:
            begin
                add_text("//");
                repeat ($urandom_range(3))
                    add_byte(alnum[$urandom_range(62)]);
                add_byte("\n");
            end
            9:  add_byte(8'($urandom));
            10: add_byte($urandom_range(1) ? "\n" : "\t");
            default:
                if ($urandom_range(3) == 0)
                    add_end();
                else
                    add_byte(clts_pkg::CH_CR);
        endcase
        add_byte(" ");
    endtask

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Drive source beats and predict on each accepted beat
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_tokens(in_beat);
                bytes_taken++;
            end
            if (!in_valid || in_ready)
            begin
                if (source_q.size() > 0 && !(idle_on && $urandom_range(99) < 27))
                begin
                    in_valid <= 1'b1;
                    in_beat  <= source_q.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Check token beats against predictions; stall the output at random
    always @(posedge clk or negedge rst_n)
    begin
        clts_pkg::out_beat_t want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                tokens_seen++;
                if (out_beat.token_kind == clts_pkg::K_ERROR)
                    errors_seen++;
                if (out_beat.token_kind >= clts_pkg::K_KEYWORD0
                    && out_beat.token_kind < clts_pkg::K_ERROR)
                    keywords_seen++;
                if (token_q.size() == 0)
                begin
                    $display("[%0t] token beat with no prediction waiting", $time);
                    fail_count++;
                end
                else
                begin
                    want = token_q.pop_front();
                    if (out_beat.token_kind != want.token_kind)
                        report("token_kind", out_beat.token_kind, want.token_kind);
                    if (out_beat.error_code != want.error_code)
                        report("error_code", out_beat.error_code, want.error_code);
                    if (out_beat.start_offset != want.start_offset)
                        report("start_offset", out_beat.start_offset, want.start_offset);
                    if (out_beat.token_length != want.token_length)
                        report("token_length", out_beat.token_length, want.token_length);
                    if (out_beat.line_number != want.line_number)
                        report("line_number", out_beat.line_number, want.line_number);
                    if (out_beat.last_of_run != want.last_of_run)
                        report("last_of_run", out_beat.last_of_run, want.last_of_run);
                end
            end
            out_ready <= !(idle_on && $urandom_range(99) < 27);
        end
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        fail_count    = 0;
        bytes_taken   = 0;
        tokens_seen   = 0;
        errors_seen   = 0;
        keywords_seen = 0;
        cycle_count   = 0;
        idle_on       = 1'b1;
        in_valid      = 1'b0;
        in_beat       = '0;
        out_ready     = 1'b0;
        rst_n         = 1'b0;
        clear_state();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: every operator and punctuator, numbers, literals, errors
        add_text("+ ++ += - -- -= -> * *= / /= % %= & &= && | |= || ^ ^= = == ");
        add_text("! != < <= << > >= >> ( ) [ ] { } , . ; ~\n");
        add_text("x9_ unsignedx 12.5 7.;\r\t'c' \"s\" @");
        add_byte(8'h00);
        add_byte(8'hFF);
        add_text(" \"ab\n'q\n// note\n");
        add_end();
        add_text("\"open");
        add_end();
        add_text("'o");
        add_end();
        add_text("// tail");
        add_end();
        add_text("3.");
        add_end();
        add_text("a/");
        add_end();

        // Hold off until the directed tokens have all come back
        wait (source_q.size() == 0 && !in_valid && token_q.size() == 0);

        // Random fragments; first a stretch with no idling on either side
        idle_on = 1'b0;
        while (source_q.size() < 40)
            add_fragment();
        wait (source_q.size() == 0);
        idle_on = 1'b1;
        while (source_q.size() < 40)
            add_fragment();
        add_end();

        wait (source_q.size() == 0 && !in_valid && token_q.size() == 0);
        repeat (20) @(posedge clk);

        $display("bytes accepted: %0d, tokens checked: %0d", bytes_taken, tokens_seen);
        $display("keyword tokens: %0d, error tokens: %0d", keywords_seen, errors_seen);
        if (fail_count == 0 && token_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
